>>> rtl/core/cndl_pkg.sv
// ---------------------------------------------------------------------------
// cndl_pkg
// shared widths, register indexes, reset limits and shape codes for the
// candlestick classifier
// ---------------------------------------------------------------------------
package cndl_pkg;

    localparam int PRICE_W  = 24;
    localparam int LIMIT_W  = 17;
    localparam int SHAPE_W  = 5;
    localparam int CFG_IDX_W = 2;

    // band products: 24-bit magnitude times 17-bit scale or limit
    localparam int BAND_W   = PRICE_W + LIMIT_W;
    // signed shadow products: 25-bit signed diff times 25-bit positive base
    localparam int SHPROD_W = 2 * (PRICE_W + 1);
    localparam int SHSUM_W  = SHPROD_W + 2;

    localparam logic [LIMIT_W-1:0] RATE_SCALE = LIMIT_W'(100000);

    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LITTLE_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_LIMIT = CFG_IDX_W'(2);

    localparam logic [LIMIT_W-1:0] CLOSE_LIMIT_RST  = LIMIT_W'(400);
    localparam logic [LIMIT_W-1:0] LITTLE_LIMIT_RST = LIMIT_W'(2000);
    localparam logic [LIMIT_W-1:0] MIDDLE_LIMIT_RST = LIMIT_W'(5000);

    localparam logic [SHAPE_W-1:0] SHAPE_LINE           = SHAPE_W'(0);
    localparam logic [SHAPE_W-1:0] SHAPE_INV_T          = SHAPE_W'(1);
    localparam logic [SHAPE_W-1:0] SHAPE_T              = SHAPE_W'(2);
    localparam logic [SHAPE_W-1:0] SHAPE_CROSS          = SHAPE_W'(3);
    localparam logic [SHAPE_W-1:0] SHAPE_LONG_CROSS     = SHAPE_W'(4);
    localparam logic [SHAPE_W-1:0] SHAPE_INV_HAMMER     = SHAPE_W'(5);
    localparam logic [SHAPE_W-1:0] SHAPE_HAMMER         = SHAPE_W'(6);
    localparam logic [SHAPE_W-1:0] SHAPE_LITTLE_LOSS    = SHAPE_W'(7);
    localparam logic [SHAPE_W-1:0] SHAPE_LITTLE_GAIN    = SHAPE_W'(8);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_HEAD_LOSS = SHAPE_W'(9);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_HEAD_GAIN = SHAPE_W'(10);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_FEET_LOSS = SHAPE_W'(11);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_FEET_GAIN = SHAPE_W'(12);
    localparam logic [SHAPE_W-1:0] SHAPE_MIDDLE_LOSS    = SHAPE_W'(13);
    localparam logic [SHAPE_W-1:0] SHAPE_MIDDLE_GAIN    = SHAPE_W'(14);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_LARGE_LOSS = SHAPE_W'(15);
    localparam logic [SHAPE_W-1:0] SHAPE_BARE_LARGE_GAIN = SHAPE_W'(16);
    localparam logic [SHAPE_W-1:0] SHAPE_LARGE_LOSS     = SHAPE_W'(17);
    localparam logic [SHAPE_W-1:0] SHAPE_LARGE_GAIN     = SHAPE_W'(18);

    // band and shadow decisions handed to the decision tree
    typedef struct packed {
        logic body_close;
        logic body_little;
        logic body_middle;
        logic range_close;
        logic range_little;
        logic lower_close;
        logic upper_close;
        logic inv_hammer;
        logic hammer;
        logic loss;
        logic bad;
    } t_flags;

endpackage

>>> rtl/core/candlestick_classifier.sv
// ---------------------------------------------------------------------------
// candlestick_classifier
// sorts one price bar (open, close, high, low) into one of 19 candle shapes
// ---------------------------------------------------------------------------
// One bar enters per clock while o_stall is low, and moves through the stages:
// stage 1 forms the price differences and their magnitudes, stage 2 does every
// multiplication (magnitudes by the rate scale, limits by the base prices,
// and the signed shadow cross products), stage 3 does the band compares and
// the shadow-ratio sums, stage 4 walks the decision tree into the output
// register. Throughput is one bar per cycle while the output is not stalled; the
// multiplier stage sets the clock. A stage holds only while everything
// downstream of it is full and the output is stalled, so bubbles collapse.
// Limits are written through the configuration port (always ready) and must
// only change while no bar is in flight. A zero close, high or low raises
// bad_input with shape line.
module candlestick_classifier
    import cndl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // bar request
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PRICE_W-1:0]   i_open_price,
    input  logic [PRICE_W-1:0]   i_close_price,
    input  logic [PRICE_W-1:0]   i_high_price,
    input  logic [PRICE_W-1:0]   i_low_price,
    // shape request
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SHAPE_W-1:0]   o_candle_shape,
    output logic                 o_bad_input,
    // limit writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LIMIT_W-1:0]   i_cfg_data
);

    // ---------------- configuration ----------------
    logic [LIMIT_W-1:0] r_close_limit;
    logic [LIMIT_W-1:0] r_little_limit;
    logic [LIMIT_W-1:0] r_middle_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close_limit  <= CLOSE_LIMIT_RST;
            r_little_limit <= LITTLE_LIMIT_RST;
            r_middle_limit <= MIDDLE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // index three is not a register, the write is dropped
            if (i_cfg_index == REG_CLOSE_LIMIT)  r_close_limit  <= i_cfg_data;
            if (i_cfg_index == REG_LITTLE_LIMIT) r_little_limit <= i_cfg_data;
            if (i_cfg_index == REG_MIDDLE_LIMIT) r_middle_limit <= i_cfg_data;
        end
    end

    // ---------------- flow control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    // a stage may load when empty or when its contents move on
    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [PRICE_W:0] n_d_body, n_d_range, n_d_low, n_d_high;
    logic [PRICE_W-1:0]      n_body_lo, n_body_hi;
    logic                    n_loss;

    logic [PRICE_W-1:0]      r1_mag_body, r1_mag_range, r1_mag_low, r1_mag_high;
    logic signed [PRICE_W:0] r1_d_low, r1_d_high;
    logic [PRICE_W-1:0]      r1_cl, r1_hi, r1_lo;
    logic                    r1_loss, r1_bad;

    function automatic logic [PRICE_W-1:0] f_mag(input logic signed [PRICE_W:0] d);
        logic signed [PRICE_W:0] neg;
        neg = -d;
        // magnitude of a difference of two prices always fits a price
        return d[PRICE_W] ? neg[PRICE_W-1:0] : d[PRICE_W-1:0];
    endfunction

    always_comb begin
        n_loss    = i_open_price > i_close_price;
        n_body_lo = n_loss ? i_close_price : i_open_price;
        n_body_hi = n_loss ? i_open_price  : i_close_price;
        n_d_body  = $signed({1'b0, i_open_price}) - $signed({1'b0, i_close_price});
        n_d_range = $signed({1'b0, i_high_price}) - $signed({1'b0, i_low_price});
        n_d_low   = $signed({1'b0, n_body_lo}) - $signed({1'b0, i_low_price});
        n_d_high  = $signed({1'b0, n_body_hi}) - $signed({1'b0, i_high_price});
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_mag_body  <= f_mag(n_d_body);
            r1_mag_range <= f_mag(n_d_range);
            r1_mag_low   <= f_mag(n_d_low);
            r1_mag_high  <= f_mag(n_d_high);
            r1_d_low     <= n_d_low;
            r1_d_high    <= n_d_high;
            r1_cl        <= i_close_price;
            r1_hi        <= i_high_price;
            r1_lo        <= i_low_price;
            r1_loss      <= n_loss;
            r1_bad       <= (i_close_price == '0) || (i_high_price == '0)
                            || (i_low_price == '0);
        end
    end

    // ---------------- stage 2: products ----------------
    logic [BAND_W-1:0] r2_body_s, r2_range_s, r2_low_s, r2_high_s;
    logic [BAND_W-1:0] r2_cl_c, r2_cl_l, r2_cl_m, r2_lo_c, r2_lo_l, r2_hi_c;
    logic signed [SHPROD_W-1:0] r2_high_lo, r2_low_hi;
    logic r2_loss, r2_bad;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_body_s  <= BAND_W'(r1_mag_body)  * BAND_W'(RATE_SCALE);
            r2_range_s <= BAND_W'(r1_mag_range) * BAND_W'(RATE_SCALE);
            r2_low_s   <= BAND_W'(r1_mag_low)   * BAND_W'(RATE_SCALE);
            r2_high_s  <= BAND_W'(r1_mag_high)  * BAND_W'(RATE_SCALE);
            r2_cl_c    <= BAND_W'(r_close_limit)  * BAND_W'(r1_cl);
            r2_cl_l    <= BAND_W'(r_little_limit) * BAND_W'(r1_cl);
            r2_cl_m    <= BAND_W'(r_middle_limit) * BAND_W'(r1_cl);
            r2_lo_c    <= BAND_W'(r_close_limit)  * BAND_W'(r1_lo);
            r2_lo_l    <= BAND_W'(r_little_limit) * BAND_W'(r1_lo);
            r2_hi_c    <= BAND_W'(r_close_limit)  * BAND_W'(r1_hi);
            r2_high_lo <= SHPROD_W'(r1_d_high) * SHPROD_W'($signed({1'b0, r1_lo}));
            r2_low_hi  <= SHPROD_W'(r1_d_low)  * SHPROD_W'($signed({1'b0, r1_hi}));
            r2_loss    <= r1_loss;
            r2_bad     <= r1_bad;
        end
    end

    // ---------------- stage 3: compares ----------------
    logic signed [SHSUM_W-1:0] n_sum_inv, n_sum_ham;
    t_flags n3_flags, r3_flags;

    always_comb begin
        // upper below minus four times lower, and lower above minus four upper
        n_sum_inv = SHSUM_W'(r2_high_lo) + (SHSUM_W'(r2_low_hi) <<< 2);
        n_sum_ham = SHSUM_W'(r2_low_hi)  + (SHSUM_W'(r2_high_lo) <<< 2);
        n3_flags.body_close   = r2_body_s  <= r2_cl_c;
        n3_flags.body_little  = r2_body_s  <= r2_cl_l;
        n3_flags.body_middle  = r2_body_s  <= r2_cl_m;
        n3_flags.range_close  = r2_range_s <= r2_lo_c;
        n3_flags.range_little = r2_range_s <= r2_lo_l;
        n3_flags.lower_close  = r2_low_s   <= r2_lo_c;
        n3_flags.upper_close  = r2_high_s  <= r2_hi_c;
        n3_flags.inv_hammer   = n_sum_inv < 0;
        n3_flags.hammer       = n_sum_ham > 0;
        n3_flags.loss         = r2_loss;
        n3_flags.bad          = r2_bad;
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) r3_flags <= n3_flags;
    end

    // ---------------- stage 4: decision tree ----------------
    logic [SHAPE_W-1:0] n_shape, r4_shape;
    logic               r4_bad;

    always_comb begin
        priority if (r3_flags.bad) begin
            n_shape = SHAPE_LINE;
        end else if (r3_flags.body_close) begin
            priority if (r3_flags.range_close)  n_shape = SHAPE_LINE;
            else if (r3_flags.lower_close)      n_shape = SHAPE_INV_T;
            else if (r3_flags.upper_close)      n_shape = SHAPE_T;
            else if (r3_flags.range_little)     n_shape = SHAPE_CROSS;
            else                                n_shape = SHAPE_LONG_CROSS;
        end else if (r3_flags.body_little) begin
            priority if (r3_flags.inv_hammer)   n_shape = SHAPE_INV_HAMMER;
            else if (r3_flags.hammer)           n_shape = SHAPE_HAMMER;
            else n_shape = r3_flags.loss ? SHAPE_LITTLE_LOSS : SHAPE_LITTLE_GAIN;
        end else if (r3_flags.body_middle) begin
            priority if (r3_flags.upper_close)
                n_shape = r3_flags.loss ? SHAPE_BARE_HEAD_LOSS : SHAPE_BARE_HEAD_GAIN;
            else if (r3_flags.lower_close)
                n_shape = r3_flags.loss ? SHAPE_BARE_FEET_LOSS : SHAPE_BARE_FEET_GAIN;
            else
                n_shape = r3_flags.loss ? SHAPE_MIDDLE_LOSS : SHAPE_MIDDLE_GAIN;
        end else begin
            // large body, bare when both shadows sit inside the tight band
            if (r3_flags.upper_close && r3_flags.lower_close)
                n_shape = r3_flags.loss ? SHAPE_BARE_LARGE_LOSS : SHAPE_BARE_LARGE_GAIN;
            else
                n_shape = r3_flags.loss ? SHAPE_LARGE_LOSS : SHAPE_LARGE_GAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_shape <= n_shape;
            r4_bad   <= r3_flags.bad;
        end
    end

    assign o_valid        = r_v4;
    assign o_candle_shape = r4_shape;
    assign o_bad_input    = r4_bad;

    // ---------------- assertions ----------------
    a_bad_is_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_input) |-> (o_candle_shape == SHAPE_LINE))
        else $error("bad bar did not give shape line");

    a_shape_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_candle_shape <= SHAPE_LARGE_GAIN))
        else $error("shape code out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_stall))
        else $error("input stalled while pipeline has room");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_v4) |=> r_v4)
        else $error("result lost between last two stages");

endmodule

>>> verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for candlestick_classifier: bars go in from a queue
// through a clocked driver, shapes are checked against an in-bench classifier
// in arrival order, and band limits are rewritten between drained phases
// ---------------------------------------------------------------------------
module tb;
    import cndl_pkg::*;

    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam longint PRICE_MAX    = 64'hFF_FFFF;
    localparam longint LIMIT_MAX    = 64'h1_FFFF;
    localparam longint SHADOW_RATIO = 4;
    localparam int     RAND_BARS    = 130;
    localparam int     PHASES       = 8;

    typedef struct packed {
        logic [PRICE_W-1:0] open_px;
        logic [PRICE_W-1:0] close_px;
        logic [PRICE_W-1:0] high_px;
        logic [PRICE_W-1:0] low_px;
    } t_bar;

    typedef struct packed {
        logic [SHAPE_W-1:0] shape;
        logic               bad;
    } t_shape;

    typedef struct packed {
        t_bar   bar;
        t_shape want;
    } t_shape_exp;

    // dut ports, every input known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [PRICE_W-1:0]   i_open_price = '0;
    logic [PRICE_W-1:0]   i_close_price = '0;
    logic [PRICE_W-1:0]   i_high_price = '0;
    logic [PRICE_W-1:0]   i_low_price = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [SHAPE_W-1:0]   o_candle_shape;
    logic                 o_bad_input;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;

    // bench copy of the band limits
    logic [LIMIT_W-1:0] tight_lim = CLOSE_LIMIT_RST;
    logic [LIMIT_W-1:0] small_lim = LITTLE_LIMIT_RST;
    logic [LIMIT_W-1:0] mid_lim   = MIDDLE_LIMIT_RST;

    t_bar       bar_q[$];     // bars waiting to be sent
    t_shape_exp shape_q[$];   // shapes owed by the dut, oldest first
    t_bar       next_bar;
    bit         bar_taken = 1'b0;
    bit         idle_en = 1'b1;
    int         send_gap = 0;
    int         stall_left = 0;
    int         fault_cnt = 0;

    candlestick_classifier i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_open_price   (i_open_price),
        .i_close_price  (i_close_price),
        .i_high_price   (i_high_price),
        .i_low_price    (i_low_price),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_candle_shape (o_candle_shape),
        .o_bad_input    (o_bad_input),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // classifier
    // ------------------------------------------------------------------

    // |diff| / base within lim / 100000, done as an exact cross product
    function automatic bit in_band(longint diff, longint base, longint lim);
        longint mag;
        mag = (diff < 0) ? -diff : diff;
        return mag * longint'(RATE_SCALE) <= lim * base;
    endfunction

    function automatic t_shape classify_bar(t_bar b);
        longint op, cl, hi, lo, body_lo, body_hi;
        longint d_body, d_low, d_high, d_range;
        longint t_lim, s_lim, m_lim;
        logic   loss;
        t_shape r;
        op = longint'(b.open_px);
        cl = longint'(b.close_px);
        hi = longint'(b.high_px);
        lo = longint'(b.low_px);
        t_lim = longint'(tight_lim);
        s_lim = longint'(small_lim);
        m_lim = longint'(mid_lim);
        r.bad = 1'b0;
        // zero base price: no rate can be formed
        if (cl == 0 || hi == 0 || lo == 0) begin
            r.shape = SHAPE_LINE;
            r.bad = 1'b1;
            return r;
        end
        body_lo = (op < cl) ? op : cl;
        body_hi = (op > cl) ? op : cl;
        d_body  = op - cl;
        d_low   = body_lo - lo;
        d_high  = body_hi - hi;
        d_range = hi - lo;
        loss    = op > cl;
        if (in_band(d_body, cl, t_lim)) begin
            // doji family
            if (in_band(d_range, lo, t_lim))      r.shape = SHAPE_LINE;
            else if (in_band(d_low, lo, t_lim))   r.shape = SHAPE_INV_T;
            else if (in_band(d_high, hi, t_lim))  r.shape = SHAPE_T;
            else if (in_band(d_range, lo, s_lim)) r.shape = SHAPE_CROSS;
            else                                  r.shape = SHAPE_LONG_CROSS;
        end else if (in_band(d_body, cl, s_lim)) begin
            // small body, shadow ratio picks the hammer kind
            if (d_high * lo < -SHADOW_RATIO * d_low * hi)
                r.shape = SHAPE_INV_HAMMER;
            else if (d_low * hi > -SHADOW_RATIO * d_high * lo)
                r.shape = SHAPE_HAMMER;
            else
                r.shape = loss ? SHAPE_LITTLE_LOSS : SHAPE_LITTLE_GAIN;
        end else if (in_band(d_body, cl, m_lim)) begin
            if (in_band(d_high, hi, t_lim))
                r.shape = loss ? SHAPE_BARE_HEAD_LOSS : SHAPE_BARE_HEAD_GAIN;
            else if (in_band(d_low, lo, t_lim))
                r.shape = loss ? SHAPE_BARE_FEET_LOSS : SHAPE_BARE_FEET_GAIN;
            else
                r.shape = loss ? SHAPE_MIDDLE_LOSS : SHAPE_MIDDLE_GAIN;
        end else begin
            if (in_band(d_high, hi, t_lim) && in_band(d_low, lo, t_lim))
                r.shape = loss ? SHAPE_BARE_LARGE_LOSS : SHAPE_BARE_LARGE_GAIN;
            else
                r.shape = loss ? SHAPE_LARGE_LOSS : SHAPE_LARGE_GAIN;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // rate in units of 1/100000, often sitting right on a band edge
    function automatic longint pick_rate();
        longint r;
        case ($urandom_range(0, 6))
            0: r = 0;
            1: r = longint'(tight_lim) + longint'($urandom_range(0, 2)) - 1;
            2: r = longint'(small_lim) + longint'($urandom_range(0, 2)) - 1;
            3: r = longint'(mid_lim) + longint'($urandom_range(0, 2)) - 1;
            4: r = longint'($urandom_range(0, 1200));
            5: r = longint'($urandom_range(0, 12000));
            default: r = longint'($urandom_range(0, 100000));
        endcase
        return (r < 0) ? 0 : r;
    endfunction

    function automatic logic [PRICE_W-1:0] clamp_price(longint v);
        if (v < 0) return '0;
        if (v > PRICE_MAX) return PRICE_MAX[PRICE_W-1:0];
        return v[PRICE_W-1:0];
    endfunction

    function automatic t_bar make_bar();
        t_bar   b;
        longint base, body, opx, top, bottom, hi, lo;
        int     r, k;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // raw noise, reaches every price bit
            b.open_px  = PRICE_W'($urandom);
            b.close_px = PRICE_W'($urandom);
            b.high_px  = PRICE_W'($urandom);
            b.low_px   = PRICE_W'($urandom);
            return b;
        end
        if (r < 13) begin
            // tiny prices, zero bases turn up often
            b.open_px  = PRICE_W'($urandom_range(0, 15));
            b.close_px = PRICE_W'($urandom_range(0, 15));
            b.high_px  = PRICE_W'($urandom_range(0, 15));
            b.low_px   = PRICE_W'($urandom_range(0, 15));
            return b;
        end
        // well formed bar around a base close price
        if ($urandom_range(0, 2) == 0) begin
            // multiple of the rate scale, so band edges come out exact
            base = 100000 * longint'($urandom_range(1, 167));
        end else begin
            k = $urandom_range(4, 24);
            base = (longint'($urandom) & ((64'd1 << k) - 1)) | (64'd1 << (k - 1));
        end
        body = base * pick_rate() / 100000;
        opx  = ($urandom_range(0, 1) == 1) ? base + body : base - body;
        top    = (opx > base) ? opx : base;
        bottom = (opx < base) ? opx : base;
        hi = top + top * pick_rate() / 100000;
        lo = bottom - bottom * pick_rate() / 100000;
        b.open_px  = clamp_price(opx);
        b.close_px = clamp_price(base);
        if (r < 20) begin
            // broken bar: high and low swapped
            b.high_px = clamp_price(lo);
            b.low_px  = clamp_price(hi);
        end else begin
            b.high_px = clamp_price(hi);
            b.low_px  = clamp_price(lo);
        end
        return b;
    endfunction

    task automatic add_bar(input longint op, input longint cl, input longint hi,
                           input longint lo);
        t_bar b;
        b.open_px  = clamp_price(op);
        b.close_px = clamp_price(cl);
        b.high_px  = clamp_price(hi);
        b.low_px   = clamp_price(lo);
        bar_q.push_back(b);
    endtask

    task automatic note_fault(input string msg);
        if (fault_cnt < 10) $display("%s", msg);
        fault_cnt++;
    endtask

    // one limit write request, only issued while no bar is in flight
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                               input logic [LIMIT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_CLOSE_LIMIT:  tight_lim = val;
            REG_LITTLE_LIMIT: small_lim = val;
            REG_MIDDLE_LIMIT: mid_lim   = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // waits until every queued bar is sent and every owed shape has come out
    task automatic drain();
        while (bar_q.size() != 0 || i_valid || shape_q.size() != 0)
            @(negedge i_clk);
        // four stage pipe, then extra idle margin before the next phase
        repeat (8) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // bar driver: changes on the falling edge, a held request stays put
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || bar_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (bar_q.size() != 0) begin
                next_bar = bar_q.pop_front();
                i_open_price  <= next_bar.open_px;
                i_close_price <= next_bar.close_px;
                i_high_price  <= next_bar.high_px;
                i_low_price   <= next_bar.low_px;
                i_valid       <= 1'b1;
                send_gap      <= idle_en ? pick_gap() : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // shape receiver back pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap();
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check the shape leaving, then log the bar entering
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_shape_exp owed;
        t_bar       seen;
        if (i_rst_n && o_valid && !i_stall) begin
            if (shape_q.size() == 0) begin
                note_fault($sformatf("unexpected shape %0d bad %0b",
                                     o_candle_shape, o_bad_input));
            end else begin
                owed = shape_q.pop_front();
                if (o_candle_shape !== owed.want.shape || o_bad_input !== owed.want.bad)
                    note_fault($sformatf(
                        "bar o=%0d c=%0d h=%0d l=%0d: shape exp %0d got %0d, bad exp %0b got %0b",
                        owed.bar.open_px, owed.bar.close_px, owed.bar.high_px,
                        owed.bar.low_px, owed.want.shape, o_candle_shape,
                        owed.want.bad, o_bad_input));
            end
        end
        bar_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            seen.open_px  = i_open_price;
            seen.close_px = i_close_price;
            seen.high_px  = i_high_price;
            seen.low_px   = i_low_price;
            owed.bar  = seen;
            owed.want = classify_bar(seen);
            shape_q.push_back(owed);
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        int p, n;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed bars under the reset limits, one per shape first
        add_bar(1000000, 1000000, 1000000, 1000000);   // line
        add_bar(1000000, 1000000, 1010000, 1000000);   // inverted t
        add_bar(1000000, 1000000, 1000000,  990000);   // t
        add_bar(1000000, 1000000, 1005000,  995000);   // cross
        add_bar(1000000, 1000000, 1020000,  980000);   // long cross
        add_bar(1010000, 1000000, 1100000, 1000000);   // inverted hammer
        add_bar(1010000, 1000000, 1010000,  900000);   // hammer
        add_bar(1010000, 1000000, 1010000, 1000000);   // little loss
        add_bar(1000000, 1010000, 1010000, 1000000);   // little gain
        add_bar(1030000, 1000000, 1030000,  990000);   // bare head loss
        add_bar(1000000, 1030000, 1030000,  990000);   // bare head gain
        add_bar(1030000, 1000000, 1040000, 1000000);   // bare feet loss
        add_bar(1000000, 1030000, 1040000, 1000000);   // bare feet gain
        add_bar(1030000, 1000000, 1040000,  990000);   // middle loss
        add_bar(1000000, 1030000, 1040000,  990000);   // middle gain
        add_bar(1100000, 1000000, 1100000, 1000000);   // bare large loss
        add_bar(1000000, 1100000, 1100000, 1000000);   // bare large gain
        add_bar(1100000, 1000000, 1200000,  900000);   // large loss
        add_bar(1000000, 1100000, 1200000,  900000);   // large gain
        // zero bases, zero open, full scale, inconsistent bars
        add_bar(0, 0, 0, 0);
        add_bar(PRICE_MAX, 0, PRICE_MAX, PRICE_MAX);
        add_bar(PRICE_MAX, PRICE_MAX, 0, PRICE_MAX);
        add_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, 0);
        add_bar(0, PRICE_MAX, PRICE_MAX, PRICE_MAX);
        add_bar(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX);
        add_bar(5, 7, 3, 9);                            // high below low
        add_bar(20, 30, 12, 10);                        // body above high

        for (p = 0; p < PHASES; p++) begin
            case (p)
                1: begin
                    write_limit(REG_CLOSE_LIMIT, '0);
                    write_limit(REG_LITTLE_LIMIT, '0);
                    write_limit(REG_MIDDLE_LIMIT, '0);
                    write_limit(REG_UNUSED, LIMIT_W'($urandom));
                end
                2: begin
                    write_limit(REG_CLOSE_LIMIT, LIMIT_MAX[LIMIT_W-1:0]);
                    write_limit(REG_LITTLE_LIMIT, LIMIT_MAX[LIMIT_W-1:0]);
                    write_limit(REG_MIDDLE_LIMIT, LIMIT_MAX[LIMIT_W-1:0]);
                end
                3: begin
                    write_limit(REG_CLOSE_LIMIT, RATE_SCALE);
                    write_limit(REG_LITTLE_LIMIT, RATE_SCALE);
                    write_limit(REG_MIDDLE_LIMIT, RATE_SCALE);
                    write_limit(REG_UNUSED, '0);
                end
                4: begin
                    write_limit(REG_MIDDLE_LIMIT, MIDDLE_LIMIT_RST);
                    write_limit(REG_LITTLE_LIMIT, LITTLE_LIMIT_RST);
                    write_limit(REG_CLOSE_LIMIT, CLOSE_LIMIT_RST);
                end
                default: begin
                    if (p > 0) begin
                        // random limits, not always in ascending order
                        write_limit(REG_CLOSE_LIMIT, LIMIT_W'($urandom_range(0, 2000)));
                        write_limit(REG_LITTLE_LIMIT, LIMIT_W'($urandom_range(0, 20000)));
                        write_limit(REG_MIDDLE_LIMIT, LIMIT_W'($urandom_range(0, 60000)));
                        write_limit(REG_UNUSED, LIMIT_W'($urandom));
                    end
                end
            endcase
            // two phases start no new gaps or stalls
            idle_en = (p != 3 && p != 6);
            for (n = 0; n < RAND_BARS; n++) bar_q.push_back(make_bar());
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (shape_q.size() != 0)
            note_fault($sformatf("%0d shapes never came out", shape_q.size()));
        if (fault_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cndl_pkg.sv
rtl/core/candlestick_classifier.sv
verif/tb.sv
